>>> sv/keyed_force_accumulator_table_defines.svh
`ifndef KEYED_FORCE_ACCUMULATOR_TABLE_DEFINES_SVH
`define KEYED_FORCE_ACCUMULATOR_TABLE_DEFINES_SVH

// Property checked on every rising edge, off while reset is asserted.
`define KFAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define KFAT_ASSERT_IMP(lbl, ante, cons, msg) \
  `KFAT_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define KFAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  `KFAT_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> sv/kfat_pkg.sv
package kfat_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned REQ_W       = 3;
  localparam int unsigned KEY_W       = 20;
  localparam int unsigned LIMIT_W     = 21;
  localparam int unsigned FORCE_W     = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 7;

  localparam logic [REQ_W-1:0] REQ_GET = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SET = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REM = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLR = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // Classified operation handed from front end to back end.
  typedef enum logic [2:0] {
    OP_GET,
    OP_ADD,
    OP_SET,
    OP_REM,
    OP_CLR,
    OP_NOP,
    OP_RANGE
  } op_e;

  typedef struct packed {
    logic signed [FORCE_W-1:0] x;
    logic signed [FORCE_W-1:0] y;
    logic signed [FORCE_W-1:0] z;
  } vec_t;

  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
    vec_t             frc;
  } cmd_t;

  localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic signed [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

  function automatic logic signed [FORCE_W-1:0] sat_add(
    input logic signed [FORCE_W-1:0] a,
    input logic signed [FORCE_W-1:0] b
  );
    logic signed [FORCE_W:0] s;
    logic signed [FORCE_W-1:0] r;
    s = {a[FORCE_W-1], a} + {b[FORCE_W-1], b};
    if (s[FORCE_W] != s[FORCE_W-1]) begin
      r = s[FORCE_W] ? FORCE_MIN : FORCE_MAX;
    end else begin
      r = s[FORCE_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> sv/kfat_if.sv
interface kfat_req_if import kfat_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic [KEY_W-1:0]          atom_id;
  logic signed [FORCE_W-1:0] force_x;
  logic signed [FORCE_W-1:0] force_y;
  logic signed [FORCE_W-1:0] force_z;

  modport source (
    output valid, req_type, atom_id, force_x, force_y, force_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, atom_id, force_x, force_y, force_z,
    output ready
  );
endinterface

interface kfat_rsp_if import kfat_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [FORCE_W-1:0] out_x;
  logic signed [FORCE_W-1:0] out_y;
  logic signed [FORCE_W-1:0] out_z;
  logic [COUNT_OUT_W-1:0]    entry_count;

  modport source (
    output valid, status, out_x, out_y, out_z, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, out_x, out_y, out_z, entry_count,
    output ready
  );
endinterface

>>> sv/kfat_front.sv
module kfat_front import kfat_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  kfat_req_if.sink           req_i,
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  logic               cmd_ready_i
);

  logic [LIMIT_W-1:0] atom_limit_q;
  logic               in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atom_limit_q <= '0;
    end else if (cfg_we_i) begin
      atom_limit_q <= cfg_wdata_i;
    end
  end

  assign in_range    = {1'b0, req_i.atom_id} < atom_limit_q;
  assign req_i.ready = cmd_ready_i;
  assign cmd_valid_o = req_i.valid;

  always_comb begin
    cmd_o.key   = req_i.atom_id;
    cmd_o.frc.x = req_i.force_x;
    cmd_o.frc.y = req_i.force_y;
    cmd_o.frc.z = req_i.force_z;
    unique case (req_i.req_type)
      REQ_GET: cmd_o.op = OP_GET;
      REQ_ADD: cmd_o.op = in_range ? OP_ADD : OP_RANGE;
      REQ_SET: cmd_o.op = in_range ? OP_SET : OP_RANGE;
      REQ_REM: cmd_o.op = OP_REM;
      REQ_CLR: cmd_o.op = OP_CLR;
      default: cmd_o.op = OP_NOP;
    endcase
  end

endmodule

>>> sv/kfat_queue.sv
module kfat_queue import kfat_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_data_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_data_o,
  input  logic pop_i
);

  localparam int unsigned PtrW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0]  PtrLast  = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [FillW-1:0] FillFull = FillW'(QUEUE_DEPTH);

  cmd_t             slots_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             push, pop;

  assign push_ready_o = fill_q != FillFull;
  assign pop_valid_o  = fill_q != '0;
  assign pop_data_o   = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push, pop})
      2'b10:   fill_d = fill_q + FillW'(1);
      2'b01:   fill_d = fill_q - FillW'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/kfat_back.sv
module kfat_back import kfat_pkg::*; #(
  parameter int unsigned MaxEntries = MAX_ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  kfat_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxEntries);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_GET  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_REM  = 3'd4;

  // Table storage, one write and one registered read port each.
  logic [KEY_W-1:0] key_mem [MaxEntries];
  vec_t             frc_mem [MaxEntries];

  logic [2:0]       state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0]  slot_q, slot_d;
  logic [KEY_W-1:0] key_rd_q;
  vec_t             frc_rd_q;

  logic             rsp_vld_q;
  status_e          rsp_status_q;
  vec_t             rsp_vec_q;
  logic [COUNT_OUT_W-1:0] rsp_cnt_q;

  logic             key_re, key_we, frc_re, frc_we;
  logic [IdxW-1:0]  key_raddr, key_waddr, frc_raddr, frc_waddr;
  logic [KEY_W-1:0] key_wdata;
  vec_t             frc_wdata;
  logic             done;
  status_e          res_status;
  vec_t             res_vec;
  logic             found, miss;
  logic [CntW-1:0]  cnt_m1;
  logic [IdxW-1:0]  last_idx, end_idx;
  logic [CntW+COUNT_OUT_W-1:0] cnt_wide;

  assign found    = cmp_vld_q && (key_rd_q == cmd_q.key);
  assign miss     = !cmp_vld_q && (idx_q >= cnt_q);
  assign cnt_m1   = cnt_q - CntW'(1);
  assign last_idx = cnt_m1[IdxW-1:0];
  assign end_idx  = cnt_q[IdxW-1:0];

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    cmp_vld_d  = cmp_vld_q;
    cmp_idx_d  = cmp_idx_q;
    slot_d     = slot_q;
    cmd_pop_o  = 1'b0;
    key_re     = 1'b0;
    key_raddr  = '0;
    frc_re     = 1'b0;
    frc_raddr  = '0;
    key_we     = 1'b0;
    key_waddr  = '0;
    key_wdata  = cmd_q.key;
    frc_we     = 1'b0;
    frc_waddr  = '0;
    frc_wdata  = cmd_q.frc;
    done       = 1'b0;
    res_status = ST_OK;
    res_vec    = '0;

    unique case (state_q)
      S_IDLE: begin
        // Start only with the result register free.
        if (cmd_valid_i && !rsp_vld_q) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = '0;
          cmp_vld_d = 1'b0;
          unique case (cmd_i.op)
            OP_CLR: begin
              cnt_d = '0;
              done  = 1'b1;
            end
            OP_NOP: done = 1'b1;
            OP_RANGE: begin
              done       = 1'b1;
              res_status = ST_RANGE;
            end
            default: state_d = S_SCAN;
          endcase
        end
      end

      S_SCAN: begin
        // Issue one key read a cycle, compare it the cycle after.
        if (idx_q < cnt_q) begin
          key_re    = 1'b1;
          key_raddr = idx_q[IdxW-1:0];
          idx_d     = idx_q + CntW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[IdxW-1:0];
        end else begin
          cmp_vld_d = 1'b0;
        end
        priority if (found) begin
          slot_d  = cmp_idx_q;
          state_d = S_IDLE;
          unique case (cmd_q.op)
            OP_GET: begin
              frc_re    = 1'b1;
              frc_raddr = cmp_idx_q;
              state_d   = S_GET;
            end
            OP_ADD: begin
              frc_re    = 1'b1;
              frc_raddr = cmp_idx_q;
              state_d   = S_ACC;
            end
            OP_SET: begin
              frc_we    = 1'b1;
              frc_waddr = cmp_idx_q;
              done      = 1'b1;
            end
            default: begin
              // Fetch the last entry to fill the hole.
              key_re    = 1'b1;
              key_raddr = last_idx;
              frc_re    = 1'b1;
              frc_raddr = last_idx;
              state_d   = S_REM;
            end
          endcase
        end else if (miss) begin
          state_d = S_IDLE;
          done    = 1'b1;
          priority if (cmd_q.op == OP_GET || cmd_q.op == OP_REM) begin
            res_status = ST_MISSING;
          end else if (cnt_q == CntMax) begin
            res_status = ST_FULL;
          end else begin
            key_we    = 1'b1;
            key_waddr = end_idx;
            frc_we    = 1'b1;
            frc_waddr = end_idx;
            cnt_d     = cnt_q + CntW'(1);
          end
        end else begin
          state_d = S_SCAN;
        end
      end

      S_GET: begin
        done    = 1'b1;
        res_vec = frc_rd_q;
        state_d = S_IDLE;
      end

      S_ACC: begin
        frc_we      = 1'b1;
        frc_waddr   = slot_q;
        frc_wdata.x = sat_add(frc_rd_q.x, cmd_q.frc.x);
        frc_wdata.y = sat_add(frc_rd_q.y, cmd_q.frc.y);
        frc_wdata.z = sat_add(frc_rd_q.z, cmd_q.frc.z);
        done        = 1'b1;
        state_d     = S_IDLE;
      end

      S_REM: begin
        key_we    = 1'b1;
        key_waddr = slot_q;
        key_wdata = key_rd_q;
        frc_we    = 1'b1;
        frc_waddr = slot_q;
        frc_wdata = frc_rd_q;
        cnt_d     = cnt_m1;
        done      = 1'b1;
        state_d   = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign cnt_wide = {{COUNT_OUT_W{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      if (done) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
    if (done) begin
      rsp_status_q <= res_status;
      rsp_vec_q    <= res_vec;
      rsp_cnt_q    <= cnt_wide[COUNT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (key_re) begin
      key_rd_q <= key_mem[key_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (frc_we) begin
      frc_mem[frc_waddr] <= frc_wdata;
    end
    if (frc_re) begin
      frc_rd_q <= frc_mem[frc_raddr];
    end
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.out_x       = rsp_vec_q.x;
  assign rsp_o.out_y       = rsp_vec_q.y;
  assign rsp_o.out_z       = rsp_vec_q.z;
  assign rsp_o.entry_count = rsp_cnt_q;

endmodule

>>> sv/keyed_force_accumulator_table.sv
// Clear, unused codes and out-of-range add or set finish from idle; add, set, get
// and remove first run a serial key scan over one memory read port, comparing
// one entry per cycle after a registered read.
// The back end takes one item at a time and starts no new one while a result
// waits on the sink. A two-item queue takes new items while the back end works.
// Reset (rst_ni, async, active low) clears entry count, atom limit and queue.
module keyed_force_accumulator_table import kfat_pkg::*; #(
  parameter int unsigned MaxEntries = MAX_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  kfat_req_if.sink           req_i,
  kfat_rsp_if.source         rsp_o
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  kfat_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  kfat_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_data_i  (cmd),
    .push_ready_o (cmd_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_cmd),
    .pop_i        (q_pop)
  );

  kfat_back #(
    .MaxEntries (MaxEntries)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .rsp_o       (rsp_o)
  );

endmodule

>>> sv/kfat_chk.sv
`include "keyed_force_accumulator_table_defines.svh"

module kfat_chk import kfat_pkg::*; #(
  parameter int unsigned MaxEntries = MAX_ENTRIES_DEF
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic [STATUS_W-1:0]       rsp_status_i,
  input logic signed [FORCE_W-1:0] rsp_x_i,
  input logic signed [FORCE_W-1:0] rsp_y_i,
  input logic signed [FORCE_W-1:0] rsp_z_i,
  input logic [COUNT_OUT_W-1:0]    rsp_count_i
);

  localparam bit CountFits = MaxEntries < (1 << COUNT_OUT_W);
  localparam logic [COUNT_OUT_W-1:0] CountMax = COUNT_OUT_W'(MaxEntries);

  `KFAT_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_count_i), "stalled item changed")
  `KFAT_ASSERT_IMP(a_err_zero, rsp_valid_i && (rsp_status_i != ST_OK), (rsp_x_i == '0) && (rsp_y_i == '0) && (rsp_z_i == '0), "failed request carries force data")
  `KFAT_ASSERT_IMP(a_count_max, rsp_valid_i && CountFits, rsp_count_i <= CountMax, "entry count above table size")
  `KFAT_ASSERT_IMP(a_full_count, rsp_valid_i && CountFits && (rsp_status_i == ST_FULL), rsp_count_i == CountMax, "table full reported below capacity")

endmodule

bind keyed_force_accumulator_table kfat_chk #(
  .MaxEntries (MaxEntries)
) u_kfat_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_x_i      (rsp_o.out_x),
  .rsp_y_i      (rsp_o.out_y),
  .rsp_z_i      (rsp_o.out_z),
  .rsp_count_i  (rsp_o.entry_count)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import kfat_pkg::*;

  localparam int unsigned TableDepth  = MAX_ENTRIES_DEF;
  localparam int unsigned DrainCycles = TableDepth + 16;
  localparam int unsigned PoolMax     = 96;

  localparam logic [LIMIT_W-1:0] LIMIT_ALL = 21'h100000;

  // Request codes the block treats as no-ops.
  localparam logic [REQ_W-1:0] REQ_RSV5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSV6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSV7 = 3'd7;

  typedef struct packed {
    status_e                   status;
    logic signed [FORCE_W-1:0] x;
    logic signed [FORCE_W-1:0] y;
    logic signed [FORCE_W-1:0] z;
    logic [COUNT_OUT_W-1:0]    count;
  } force_rsp_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata_i = '0;

  kfat_req_if req_bus ();
  kfat_rsp_if rsp_bus ();

  keyed_force_accumulator_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the force table.
  logic [KEY_W-1:0]          ent_key [TableDepth];
  logic signed [FORCE_W-1:0] ent_fx  [TableDepth];
  logic signed [FORCE_W-1:0] ent_fy  [TableDepth];
  logic signed [FORCE_W-1:0] ent_fz  [TableDepth];
  int unsigned               ent_used;
  logic [LIMIT_W-1:0]        atom_limit_q;

  force_rsp_t       owed_rsp[$];
  int unsigned      fail_count;
  bit               req_held;
  int unsigned      burst_left;
  logic [KEY_W-1:0] key_pool [PoolMax];
  int unsigned      pool_n;

  logic [15:0] stall_tick = '0;
  logic [1:0]  stall_mode = '0;
  logic [31:0] stall_pat  = '0;

  function automatic int find_entry(logic [KEY_W-1:0] key);
    for (int i = 0; i < ent_used; i++) begin
      if (ent_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic logic signed [FORCE_W-1:0] sat_sum(logic signed [FORCE_W-1:0] a,
                                                        logic signed [FORCE_W-1:0] b);
    longint wide;
    wide = longint'(a) + longint'(b);
    if (wide > longint'(FORCE_MAX)) return FORCE_MAX;
    if (wide < longint'(FORCE_MIN)) return FORCE_MIN;
    return wide[FORCE_W-1:0];
  endfunction

  function automatic status_e store_entry(logic [KEY_W-1:0] key,
                                          logic signed [FORCE_W-1:0] x,
                                          logic signed [FORCE_W-1:0] y,
                                          logic signed [FORCE_W-1:0] z,
                                          bit accum);
    int slot;
    if ({1'b0, key} >= atom_limit_q) return ST_RANGE;
    slot = find_entry(key);
    if (slot >= 0) begin
      if (accum) begin
        ent_fx[slot] = sat_sum(ent_fx[slot], x);
        ent_fy[slot] = sat_sum(ent_fy[slot], y);
        ent_fz[slot] = sat_sum(ent_fz[slot], z);
      end else begin
        ent_fx[slot] = x;
        ent_fy[slot] = y;
        ent_fz[slot] = z;
      end
      return ST_OK;
    end
    if (ent_used >= TableDepth) return ST_FULL;
    ent_key[ent_used] = key;
    ent_fx[ent_used]  = x;
    ent_fy[ent_used]  = y;
    ent_fz[ent_used]  = z;
    ent_used++;
    return ST_OK;
  endfunction

  function automatic void predict_table(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                                        logic signed [FORCE_W-1:0] x,
                                        logic signed [FORCE_W-1:0] y,
                                        logic signed [FORCE_W-1:0] z);
    force_rsp_t r;
    int slot;
    r = '0;
    r.status = ST_OK;
    case (req)
      REQ_GET: begin
        slot = find_entry(key);
        if (slot >= 0) begin
          r.x = ent_fx[slot];
          r.y = ent_fy[slot];
          r.z = ent_fz[slot];
        end else begin
          r.status = ST_MISSING;
        end
      end
      REQ_ADD: r.status = store_entry(key, x, y, z, 1'b1);
      REQ_SET: r.status = store_entry(key, x, y, z, 1'b0);
      REQ_REM: begin
        slot = find_entry(key);
        if (slot >= 0) begin
          // Move the last entry into the hole.
          ent_key[slot] = ent_key[ent_used-1];
          ent_fx[slot]  = ent_fx[ent_used-1];
          ent_fy[slot]  = ent_fy[ent_used-1];
          ent_fz[slot]  = ent_fz[ent_used-1];
          ent_used--;
        end else begin
          r.status = ST_MISSING;
        end
      end
      REQ_CLR: ent_used = 0;
      default: ;
    endcase
    r.count = COUNT_OUT_W'(ent_used);
    owed_rsp.push_back(r);
  endfunction

  function automatic void report_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  always @(negedge clk_i) begin : rsp_check
    force_rsp_t exp_r;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (owed_rsp.size() == 0) begin
        report_fail($sformatf("result with none owed: status %0d count %0d",
                              rsp_bus.status, rsp_bus.entry_count));
      end else begin
        exp_r = owed_rsp.pop_front();
        if (rsp_bus.status !== exp_r.status || rsp_bus.out_x !== exp_r.x ||
            rsp_bus.out_y !== exp_r.y || rsp_bus.out_z !== exp_r.z ||
            rsp_bus.entry_count !== exp_r.count) begin
          report_fail($sformatf({"status %0d/%0d x %h/%h y %h/%h z %h/%h count %0d/%0d",
                                 " (expected/actual)"},
                                exp_r.status, rsp_bus.status, exp_r.x, rsp_bus.out_x,
                                exp_r.y, rsp_bus.out_y, exp_r.z, rsp_bus.out_z,
                                exp_r.count, rsp_bus.entry_count));
        end
      end
    end
  end

  // Receiver back-pressure: free flow, coin flips, a rotating pattern, or long stalls.
  always @(posedge clk_i) begin : rsp_stall
    stall_tick <= stall_tick + 16'd1;
    if (stall_tick[8:0] == '1) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_pat  <= $urandom;
    end
    case (stall_mode)
      2'd0:    rsp_bus.ready <= 1'b1;
      2'd1:    rsp_bus.ready <= 1'($urandom_range(0, 1));
      2'd2:    rsp_bus.ready <= stall_pat[stall_tick[4:0]];
      default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic hold_off(int unsigned n);
    if (req_held) begin
      req_bus.valid <= 1'b0;
      req_held = 1'b0;
    end
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    hold_off(0);
    while (owed_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_item(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                           logic signed [FORCE_W-1:0] x,
                           logic signed [FORCE_W-1:0] y,
                           logic signed [FORCE_W-1:0] z);
    bit taken;
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= req;
    req_bus.atom_id  <= key;
    req_bus.force_x  <= x;
    req_bus.force_y  <= y;
    req_bus.force_z  <= z;
    req_held = 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = req_bus.ready;
      @(posedge clk_i);
    end
    predict_table(req, key, x, y, z);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      hold_off($urandom_range(1, 10));
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    atom_limit_q = value;
  endtask

  function automatic logic signed [FORCE_W-1:0] rand_force();
    case ($urandom_range(0, 9))
      0:       return FORCE_MAX;
      1:       return FORCE_MIN;
      2:       return FORCE_W'(int'($urandom_range(0, 262143)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  function automatic void fill_pool(int unsigned n);
    pool_n = n;
    for (int i = 0; i < n; i++) begin
      if (atom_limit_q != 0 && $urandom_range(0, 4) != 0)
        key_pool[i] = KEY_W'($urandom_range(0, atom_limit_q - 1));
      else
        key_pool[i] = KEY_W'($urandom);
    end
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, pool_n - 1)];
    return KEY_W'($urandom);
  endfunction

  function automatic logic [REQ_W-1:0] pick_req();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return REQ_GET;
    if (sel < 55) return REQ_ADD;
    if (sel < 72) return REQ_SET;
    if (sel < 88) return REQ_REM;
    if (sel < 90) return REQ_CLR;
    case ($urandom_range(0, 2))
      0:       return REQ_RSV5;
      1:       return REQ_RSV6;
      default: return REQ_RSV7;
    endcase
  endfunction

  task automatic test_directed();
    write_limit(21'd16);
    send_item(REQ_GET, 20'd0, 32'sd0, 32'sd0, 32'sd0);
    send_item(REQ_REM, 20'd0, 32'sd0, 32'sd0, 32'sd0);
    send_item(REQ_SET, 20'd3, FORCE_MAX, FORCE_MIN, 32'sd0);
    // Saturate high and low, and cross zero without saturating.
    send_item(REQ_ADD, 20'd3, FORCE_MAX, FORCE_MIN, -32'sd1);
    send_item(REQ_GET, 20'd3, 32'sd5, 32'sd5, 32'sd5);
    send_item(REQ_ADD, 20'd15, 32'sh0001_8000, -32'sh0002_4000, 32'sh7FFF_0000);
    send_item(REQ_SET, 20'd16, 32'sd1, 32'sd2, 32'sd3);
    send_item(REQ_ADD, 20'hFFFFF, 32'sd1, 32'sd2, 32'sd3);
    send_item(REQ_GET, 20'd16, 32'sd0, 32'sd0, 32'sd0);
    send_item(REQ_REM, 20'd7, 32'sd0, 32'sd0, 32'sd0);
    send_item(REQ_REM, 20'd3, 32'sd0, 32'sd0, 32'sd0);
    send_item(REQ_GET, 20'd15, 32'sd0, 32'sd0, 32'sd0);
    // One entry left: a remove with another key must miss.
    send_item(REQ_REM, 20'd9, 32'sd0, 32'sd0, 32'sd0);
    send_item(REQ_RSV5, 20'hFFFFF, FORCE_MAX, FORCE_MAX, FORCE_MAX);
    send_item(REQ_RSV6, 20'd15, FORCE_MIN, FORCE_MIN, FORCE_MIN);
    send_item(REQ_RSV7, 20'd0, -32'sd1, -32'sd1, -32'sd1);
    send_item(REQ_CLR, 20'hFFFFF, FORCE_MAX, FORCE_MIN, -32'sd1);
    send_item(REQ_GET, 20'd15, 32'sd0, 32'sd0, 32'sd0);
    send_item(REQ_ADD, 20'd0, -32'sd1, -32'sd1, -32'sd1);
    send_item(REQ_ADD, 20'd0, FORCE_MIN, FORCE_MIN, FORCE_MIN);
    send_item(REQ_GET, 20'd0, 32'sd0, 32'sd0, 32'sd0);
  endtask

  task automatic test_limit_extremes();
    write_limit('0);
    send_item(REQ_ADD, 20'd0, 32'sd1, 32'sd1, 32'sd1);
    send_item(REQ_SET, 20'd5, 32'sd1, 32'sd1, 32'sd1);
    send_item(REQ_GET, 20'd0, 32'sd0, 32'sd0, 32'sd0);
    write_limit(LIMIT_ALL);
    send_item(REQ_ADD, 20'hFFFFF, FORCE_MAX, 32'sd0, FORCE_MIN);
    send_item(REQ_SET, 20'd0, 32'sd7, 32'sd8, 32'sd9);
    send_item(REQ_GET, 20'hFFFFF, 32'sd0, 32'sd0, 32'sd0);
    write_limit(21'd1);
    send_item(REQ_ADD, 20'd1, 32'sd1, 32'sd1, 32'sd1);
    send_item(REQ_ADD, 20'd0, 32'sd1, 32'sd1, 32'sd1);
    send_item(REQ_SET, 20'hFFFFF, 32'sd1, 32'sd1, 32'sd1);
    send_item(REQ_REM, 20'hFFFFF, 32'sd0, 32'sd0, 32'sd0);
  endtask

  task automatic test_table_full();
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] stride;
    write_limit(LIMIT_ALL);
    base   = KEY_W'($urandom);
    stride = KEY_W'(2 * $urandom_range(0, 262143) + 1);
    send_item(REQ_CLR, '0, '0, '0, '0);
    // An odd stride keeps all keys distinct.
    for (int i = 0; i < TableDepth; i++) begin
      send_item($urandom_range(0, 1) ? REQ_ADD : REQ_SET, base + KEY_W'(i) * stride,
                rand_force(), rand_force(), rand_force());
    end
    send_item(REQ_ADD, base + KEY_W'(TableDepth) * stride, 32'sd1, 32'sd1, 32'sd1);
    send_item(REQ_SET, base + KEY_W'(TableDepth) * stride, 32'sd1, 32'sd1, 32'sd1);
    send_item(REQ_ADD, base, rand_force(), rand_force(), rand_force());
    send_item(REQ_GET, base, '0, '0, '0);
    send_item(REQ_REM, base + KEY_W'(5) * stride, '0, '0, '0);
    send_item(REQ_GET, base + KEY_W'(TableDepth - 1) * stride, '0, '0, '0);
    send_item(REQ_SET, base + KEY_W'(TableDepth) * stride, rand_force(), rand_force(),
              rand_force());
    send_item(REQ_ADD, base + KEY_W'(TableDepth + 1) * stride, 32'sd1, 32'sd1, 32'sd1);
    send_item(REQ_GET, base + KEY_W'(TableDepth) * stride, '0, '0, '0);
  endtask

  task automatic test_random_traffic(int unsigned total);
    logic [LIMIT_W-1:0] lim;
    int unsigned per_phase;
    per_phase = total / 6;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0, 4:    lim = LIMIT_ALL;
        1:       lim = LIMIT_W'($urandom_range(1, 40));
        2:       lim = LIMIT_W'($urandom_range(1, LIMIT_ALL));
        3:       lim = LIMIT_W'($urandom_range(64, 200));
        default: lim = LIMIT_W'($urandom_range(1, 8));
      endcase
      write_limit(lim);
      fill_pool($urandom_range(4, PoolMax));
      for (int i = 0; i < per_phase; i++) begin
        // Hold the sender until the block has answered everything.
        if (ph == 2 && i == per_phase / 2) wait_drained();
        send_item(pick_req(), pick_key(), rand_force(), rand_force(), rand_force());
      end
    end
  endtask

  task automatic finish_run();
    int unsigned waited;
    hold_off(0);
    waited = 0;
    while (owed_rsp.size() != 0 && waited < 50000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && owed_rsp.size() == 0) begin
      $display("keyed_force_accumulator_table: match");
    end else begin
      $display("keyed_force_accumulator_table: mismatch");
    end
    $finish;
  endtask

  initial begin
    req_bus.valid    = 1'b0;
    req_bus.req_type = '0;
    req_bus.atom_id  = '0;
    req_bus.force_x  = '0;
    req_bus.force_y  = '0;
    req_bus.force_z  = '0;
    rsp_bus.ready    = 1'b0;
    req_held     = 1'b0;
    burst_left   = 0;
    fail_count   = 0;
    ent_used     = 0;
    atom_limit_q = '0;
    pool_n       = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limit_extremes();
    test_table_full();
    test_random_traffic(546);
    finish_run();
  end

  initial begin
    #14_400_000;
    $display("keyed_force_accumulator_table: mismatch");
    $finish;
  end

endmodule
